>>> hdl/dfbc_pkg.sv
// shared types and constants for the dual fetch bank conflict check
// no dependencies; imported by every module of the block
package dfbc_pkg;

    // field widths
    localparam int ADDR_W     = 48;
    localparam int LEN_W      = 12;
    localparam int FBB_W      = 8;
    localparam int PAGE_BITS  = 12;
    localparam int LEN_MAX    = 4095;
    localparam int INST_BYTES = 4;

    // cache line and bank geometry (line size is a power of two)
    localparam int LINE_BYTES = 64;
    localparam int BANK_BYTES = 8;
    localparam int BANK_COUNT = 8;
    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int NUM_BANKS  = (LINE_BYTES + BANK_BYTES - 1) / BANK_BYTES;
    localparam int CNT_W      = $clog2(NUM_BANKS + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUAL_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FETCH_BUF = 2'd1;
    localparam logic [FBB_W-1:0]     FBB_RESET     = 8'd64;

    typedef enum logic [2:0] {
        VERDICT_IDLE     = 3'd0,
        VERDICT_DUAL     = 3'd1,
        VERDICT_SINGLE   = 3'd2,
        VERDICT_BAD_PC   = 3'd3,
        VERDICT_PAGE     = 3'd4,
        VERDICT_FALLTHRU = 3'd5,
        VERDICT_CONFLICT = 3'd6
    } verdict_t;

    // range facts handed from the address stage to the bank check
    typedef struct packed {
        logic [LEN_W-1:0] len0;
        logic [LEN_W-1:0] len1;
        logic             pcs_ok;
        logic             page_ok;
        logic             second_above;
        logic             dist_far;
        logic [OFF_W:0]   gap;
        logic [OFF_W-1:0] lo_off;
        logic [OFF_W-1:0] off0;
        logic [OFF_W-1:0] off1;
    } range_info_t;

endpackage

>>> hdl/dual_fetch_bank_conflict_check_unit.sv
// top level: config registers, input register, verdict logic, result register
// depends on dfbc_pkg, dfbc_range_calc, dfbc_bank_check

// Each request word yields one result word. A word sits in the input register while the
// address arithmetic and the bank masks are evaluated, then lands in the
// result register: m_valid rises at the clock edge right after the accepting edge when the
// result register is free, and a new word is taken every cycle as long as the result side
// keeps up (one word per cycle sustained, set by the single input and result register
// pair). Configuration writes take effect on the next clock and should only be issued
// while no word is in flight.
module dual_fetch_bank_conflict_check_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [dfbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfbc_pkg::FBB_W-1:0]        cfg_wdata,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_need_entry,
    input  logic                              s_dual_allowed,
    input  logic [dfbc_pkg::ADDR_W-1:0]       s_first_fetch_pc,
    input  logic [dfbc_pkg::ADDR_W-1:0]       s_second_fetch_pc,
    input  logic [dfbc_pkg::ADDR_W-1:0]       s_first_entry_start,
    input  logic [dfbc_pkg::ADDR_W-1:0]       s_first_branch_pc,
    input  logic                              s_first_taken,
    input  logic [dfbc_pkg::ADDR_W-1:0]       s_second_entry_start,
    input  logic [dfbc_pkg::ADDR_W-1:0]       s_second_branch_pc,
    input  logic                              s_second_taken,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_verdict,
    output logic [dfbc_pkg::LEN_W-1:0]        m_first_valid_len,
    output logic [dfbc_pkg::LEN_W-1:0]        m_second_valid_len
);
    import dfbc_pkg::*;

    // configuration registers
    logic             dual_en_reg, dual_en_next;
    logic [FBB_W-1:0] fbb_reg, fbb_next;

    always_comb begin
        dual_en_next = dual_en_reg;
        fbb_next     = fbb_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_DUAL_EN:   dual_en_next = cfg_wdata[0];
                CFG_FETCH_BUF: fbb_next     = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dual_en_reg <= 1'b0;
            fbb_reg     <= FBB_RESET;
        end else begin
            dual_en_reg <= dual_en_next;
            fbb_reg     <= fbb_next;
        end
    end

    // handshake control
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s_accept, advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input word register
    logic              need_reg, allowed_reg, taken0_reg, taken1_reg;
    logic [ADDR_W-1:0] fpc0_reg, fpc1_reg, start0_reg, start1_reg, br0_reg, br1_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            need_reg    <= s_need_entry;
            allowed_reg <= s_dual_allowed;
            fpc0_reg    <= s_first_fetch_pc;
            fpc1_reg    <= s_second_fetch_pc;
            start0_reg  <= s_first_entry_start;
            br0_reg     <= s_first_branch_pc;
            taken0_reg  <= s_first_taken;
            start1_reg  <= s_second_entry_start;
            br1_reg     <= s_second_branch_pc;
            taken1_reg  <= s_second_taken;
        end
    end

    // address arithmetic and bank check
    range_info_t info;
    logic        conflict;

    dfbc_range_calc u_range (
        .first_fetch_pc     (fpc0_reg),
        .second_fetch_pc    (fpc1_reg),
        .first_entry_start  (start0_reg),
        .first_branch_pc    (br0_reg),
        .second_entry_start (start1_reg),
        .second_branch_pc   (br1_reg),
        .fetch_buffer_bytes (fbb_reg),
        .info               (info)
    );

    dfbc_bank_check u_bank (
        .info     (info),
        .conflict (conflict)
    );

    // verdict in priority order
    verdict_t         verdict_next, verdict_reg;
    logic [LEN_W-1:0] len0_next, len1_next, len0_reg, len1_reg;

    always_comb begin
        if (!need_reg) begin
            verdict_next = VERDICT_IDLE;
        end else if (!(dual_en_reg && allowed_reg)) begin
            verdict_next = VERDICT_SINGLE;
        end else if (!info.pcs_ok) begin
            verdict_next = VERDICT_BAD_PC;
        end else if (!info.page_ok) begin
            verdict_next = VERDICT_PAGE;
        end else if (!(taken0_reg && taken1_reg)) begin
            verdict_next = VERDICT_FALLTHRU;
        end else if (conflict) begin
            verdict_next = VERDICT_CONFLICT;
        end else begin
            verdict_next = VERDICT_DUAL;
        end
    end

    // lengths per verdict
    always_comb begin
        case (verdict_next)
            VERDICT_IDLE: begin
                len0_next = '0;
                len1_next = '0;
            end
            VERDICT_DUAL: begin
                len0_next = info.len0;
                len1_next = info.len1;
            end
            default: begin
                len0_next = LEN_W'(fbb_reg);
                len1_next = '0;
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            verdict_reg <= verdict_next;
            len0_reg    <= len0_next;
            len1_reg    <= len1_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_verdict          = verdict_reg;
    assign m_first_valid_len  = len0_reg;
    assign m_second_valid_len = len1_reg;

    // an empty result register never holds off the request side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("s_ready low with empty result register");

    // a word leaving the input register shows up as a result
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced word did not reach the result register");

    // a blocked input register refuses new words
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("new word accepted while pipeline is stalled");

endmodule

>>> hdl/dfbc_range_calc.sv
// address arithmetic: entry lengths, page span, start distance
// depends on dfbc_pkg
module dfbc_range_calc (
    input  logic [dfbc_pkg::ADDR_W-1:0] first_fetch_pc,
    input  logic [dfbc_pkg::ADDR_W-1:0] second_fetch_pc,
    input  logic [dfbc_pkg::ADDR_W-1:0] first_entry_start,
    input  logic [dfbc_pkg::ADDR_W-1:0] first_branch_pc,
    input  logic [dfbc_pkg::ADDR_W-1:0] second_entry_start,
    input  logic [dfbc_pkg::ADDR_W-1:0] second_branch_pc,
    input  logic [dfbc_pkg::FBB_W-1:0]  fetch_buffer_bytes,
    output dfbc_pkg::range_info_t       info
);
    import dfbc_pkg::*;

    // branch minus start plus one instruction, modulo the address space, saturated
    function automatic logic [LEN_W-1:0] entry_len(input logic [ADDR_W-1:0] start,
                                                    input logic [ADDR_W-1:0] branch);
        logic [ADDR_W-1:0] diff;
        logic              sat;
        diff = branch - start;
        sat  = (diff[ADDR_W-1:LEN_W] != '0) ||
               (diff[LEN_W-1:0] > LEN_W'(LEN_MAX - INST_BYTES));
        return sat ? LEN_W'(LEN_MAX) : diff[LEN_W-1:0] + LEN_W'(INST_BYTES);
    endfunction

    logic [ADDR_W:0] end0, end1;
    logic [ADDR_W:0] d_fwd, d_rev;
    logic [ADDR_W-1:0] dist_full;

    // last byte of each fetch, one bit wider so it never wraps
    assign end0 = {1'b0, first_fetch_pc} + (ADDR_W+1)'(fetch_buffer_bytes) - (ADDR_W+1)'(1);
    assign end1 = {1'b0, second_fetch_pc} + (ADDR_W+1)'(fetch_buffer_bytes) - (ADDR_W+1)'(1);

    // both directions of the start distance in parallel, pick by borrow
    assign d_fwd = {1'b0, second_entry_start} - {1'b0, first_entry_start};
    assign d_rev = {1'b0, first_entry_start} - {1'b0, second_entry_start};
    assign dist_full = d_fwd[ADDR_W] ? d_rev[ADDR_W-1:0] : d_fwd[ADDR_W-1:0];

    always_comb begin
        info.len0    = entry_len(first_entry_start, first_branch_pc);
        info.len1    = entry_len(second_entry_start, second_branch_pc);
        info.pcs_ok  = (first_fetch_pc != '0) && (second_fetch_pc != '0);
        info.page_ok = (first_fetch_pc[ADDR_W-1:PAGE_BITS] == second_fetch_pc[ADDR_W-1:PAGE_BITS])
                    && (end0[ADDR_W:PAGE_BITS] == {1'b0, first_fetch_pc[ADDR_W-1:PAGE_BITS]})
                    && (end1[ADDR_W:PAGE_BITS] == {1'b0, second_fetch_pc[ADDR_W-1:PAGE_BITS]});
        info.second_above = !d_fwd[ADDR_W];
        info.dist_far = (dist_full[ADDR_W-1:OFF_W+1] != '0) ||
                        (dist_full[OFF_W:0] > (OFF_W+1)'(LINE_BYTES));
        info.gap      = dist_full[OFF_W:0];
        info.lo_off   = d_fwd[ADDR_W] ? second_entry_start[OFF_W-1:0]
                                      : first_entry_start[OFF_W-1:0];
        info.off0     = first_entry_start[OFF_W-1:0];
        info.off1     = second_entry_start[OFF_W-1:0];
    end

endmodule

>>> hdl/dfbc_bank_check.sv
// bank conflict decision from the two entry ranges
// depends on dfbc_pkg
module dfbc_bank_check (
    input  dfbc_pkg::range_info_t info,
    output logic                  conflict
);
    import dfbc_pkg::*;

    // bytes of one line touched by a range starting at off, n bytes long
    function automatic logic [LINE_BYTES-1:0] byte_mask(input logic [OFF_W-1:0] off,
                                                         input logic [OFF_W:0]   n);
        logic [LINE_BYTES-1:0] m;
        logic [OFF_W-1:0]      rel;
        for (int k = 0; k < LINE_BYTES; k++) begin
            rel  = OFF_W'(k) - off;
            m[k] = ({1'b0, rel} < n);
        end
        return m;
    endfunction

    // fold bytes into banks
    function automatic logic [NUM_BANKS-1:0] bank_mask(input logic [LINE_BYTES-1:0] bytes);
        logic [NUM_BANKS-1:0] b;
        b = '0;
        for (int k = 0; k < LINE_BYTES; k++) begin
            b[k / BANK_BYTES] = b[k / BANK_BYTES] | bytes[k];
        end
        return b;
    endfunction

    // clamp a length to one line
    function automatic logic [OFF_W:0] clamp_line(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(LINE_BYTES)) ? (OFF_W+1)'(LINE_BYTES) : len[OFF_W:0];
    endfunction

    logic [LEN_W:0]       reach;
    logic [LEN_W:0]       near_len;
    logic [LEN_W:0]       span;
    logic                 fits;
    logic [NUM_BANKS-1:0] union_banks, banks0, banks1;
    logic [CNT_W-1:0]     union_cnt;

    // span of the union measured from the lower start
    always_comb begin
        if (info.second_above) begin
            reach    = (LEN_W+1)'(info.gap) + {1'b0, info.len1};
            near_len = {1'b0, info.len0};
        end else begin
            reach    = (LEN_W+1)'(info.gap) + {1'b0, info.len0};
            near_len = {1'b0, info.len1};
        end
        span = (reach > near_len) ? reach : near_len;
        fits = !info.dist_far && (span <= (LEN_W+1)'(LINE_BYTES));
    end

    assign union_banks = bank_mask(byte_mask(info.lo_off, span[OFF_W:0]));
    assign banks0      = bank_mask(byte_mask(info.off0, clamp_line(info.len0)));
    assign banks1      = bank_mask(byte_mask(info.off1, clamp_line(info.len1)));

    // distinct banks of the union
    always_comb begin
        union_cnt = '0;
        for (int j = 0; j < NUM_BANKS; j++) begin
            union_cnt = union_cnt + CNT_W'(union_banks[j]);
        end
    end

    assign conflict = fits ? (int'(union_cnt) > BANK_COUNT) : (|(banks0 & banks1));

endmodule

>>> bench/testbench.sv
// testbench for dual_fetch_bank_conflict_check_unit: directed and random request words,
// checked one for one against a verdict predictor kept in a small scoreboard class
// depends on dfbc_pkg and the block's top level only
module testbench;
    import dfbc_pkg::*;

    // one request word and one verdict word as seen on the ports
    typedef struct packed {
        logic              need_entry;
        logic              dual_allowed;
        logic [ADDR_W-1:0] first_fetch_pc;
        logic [ADDR_W-1:0] second_fetch_pc;
        logic [ADDR_W-1:0] first_entry_start;
        logic [ADDR_W-1:0] first_branch_pc;
        logic              first_taken;
        logic [ADDR_W-1:0] second_entry_start;
        logic [ADDR_W-1:0] second_branch_pc;
        logic              second_taken;
    } request_t;

    typedef struct packed {
        verdict_t         verdict;
        logic [LEN_W-1:0] first_len;
        logic [LEN_W-1:0] second_len;
    } result_t;

    localparam logic [63:0] PAGE_BASE_MASK = ~((64'd1 << PAGE_BITS) - 64'd1);
    localparam int NUM_PHASES = 8;
    localparam int PHASE_WORDS = 188;

    // verdict predictor with its own copy of the two registers
    class dual_verdict_board;
        logic             dual_enable;
        logic [FBB_W-1:0] fetch_buf;
        result_t          pending_verdicts[$];
        int unsigned      errors;
        int unsigned      requests;
        int unsigned      verdict_count[8];

        function new();
            dual_enable = 1'b0;
            fetch_buf   = FBB_RESET;
            errors      = 0;
            requests    = 0;
            foreach (verdict_count[i]) verdict_count[i] = 0;
        endfunction

        task flag_mismatch(input string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        function void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FBB_W-1:0] val);
            if (idx == CFG_DUAL_EN) begin
                dual_enable = val[0];
            end else if (idx == CFG_FETCH_BUF) begin
                fetch_buf = val;
            end
        endfunction

        // branch minus start plus one instruction, modulo the address space, saturated
        function logic [LEN_W-1:0] range_len(input logic [ADDR_W-1:0] start,
                                             input logic [ADDR_W-1:0] branch);
            logic [ADDR_W-1:0] delta;
            logic [63:0]       span;
            delta = branch - start;
            span  = 64'(delta);
            span  = span + 64'(INST_BYTES);
            if (span > 64'(LEN_MAX)) return LEN_W'(LEN_MAX);
            return span[LEN_W-1:0];
        endfunction

        // banks touched by a byte range, wrapping in the line; one line at most matters
        function logic [LINE_BYTES-1:0] bank_mask(input logic [63:0] addr,
                                                  input logic [63:0] len);
            logic [LINE_BYTES-1:0] m;
            logic [63:0]           n;
            logic [63:0]           bank;
            m = '0;
            n = (len > 64'(LINE_BYTES)) ? 64'(LINE_BYTES) : len;
            for (longint unsigned i = 0; i < n; i++) begin
                bank = ((addr + i) % LINE_BYTES) / BANK_BYTES;
                m[bank] = 1'b1;
            end
            return m;
        endfunction

        function logic banks_collide(input logic [63:0] a0, input logic [63:0] l0,
                                     input logic [63:0] a1, input logic [63:0] l1);
            logic [63:0] lo;
            logic [63:0] hi;
            lo = (a0 < a1) ? a0 : a1;
            hi = (a0 + l0 > a1 + l1) ? a0 + l0 : a1 + l1;
            // union inside one line: count distinct banks
            if (hi - lo <= LINE_BYTES)
                return $countones(bank_mask(lo, hi - lo)) > BANK_COUNT;
            return |(bank_mask(a0, l0) & bank_mask(a1, l1));
        endfunction

        function result_t predict_verdict(input request_t r);
            result_t          res;
            logic [63:0]      p0, p1, pg0, pg1, ep0, ep1, fb, s0, s1;
            logic [LEN_W-1:0] len0, len1;
            res.verdict    = VERDICT_IDLE;
            res.first_len  = '0;
            res.second_len = '0;
            if (!r.need_entry) return res;
            fb            = 64'(fetch_buf);
            res.first_len = LEN_W'(fetch_buf);
            p0 = 64'(r.first_fetch_pc);
            p1 = 64'(r.second_fetch_pc);
            if (!(dual_enable && r.dual_allowed)) begin
                res.verdict = VERDICT_SINGLE;
            end else if (p0 == 0 || p1 == 0) begin
                res.verdict = VERDICT_BAD_PC;
            end else begin
                // fetch end computed without wrap at the top of the address space
                pg0 = p0 & PAGE_BASE_MASK;
                pg1 = p1 & PAGE_BASE_MASK;
                ep0 = (p0 + fb - 64'd1) & PAGE_BASE_MASK;
                ep1 = (p1 + fb - 64'd1) & PAGE_BASE_MASK;
                if (pg0 != pg1 || ep0 != pg0 || ep1 != pg1 || ep0 != ep1) begin
                    res.verdict = VERDICT_PAGE;
                end else if (!r.first_taken || !r.second_taken) begin
                    res.verdict = VERDICT_FALLTHRU;
                end else begin
                    len0 = range_len(r.first_entry_start, r.first_branch_pc);
                    len1 = range_len(r.second_entry_start, r.second_branch_pc);
                    s0   = 64'(r.first_entry_start);
                    s1   = 64'(r.second_entry_start);
                    if (banks_collide(s0, {52'b0, len0}, s1, {52'b0, len1})) begin
                        res.verdict = VERDICT_CONFLICT;
                    end else begin
                        res.verdict    = VERDICT_DUAL;
                        res.first_len  = len0;
                        res.second_len = len1;
                    end
                end
            end
            return res;
        endfunction

        function void note_request(input request_t r);
            result_t e;
            e = predict_verdict(r);
            pending_verdicts.push_back(e);
            verdict_count[e.verdict]++;
            requests++;
        endfunction

        task check_result(input logic [2:0] verdict, input logic [LEN_W-1:0] len0,
                          input logic [LEN_W-1:0] len1);
            result_t e;
            if (pending_verdicts.size() == 0) begin
                flag_mismatch($sformatf("verdict word %0d with nothing outstanding", verdict));
                return;
            end
            e = pending_verdicts.pop_front();
            if (verdict !== e.verdict)
                flag_mismatch($sformatf("verdict %0d, want %0d (%s)", verdict, e.verdict,
                                        e.verdict.name()));
            if (len0 !== e.first_len)
                flag_mismatch($sformatf("first_valid_len %0d, want %0d", len0, e.first_len));
            if (len1 !== e.second_len)
                flag_mismatch($sformatf("second_valid_len %0d, want %0d", len1, e.second_len));
        endtask
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FBB_W-1:0]     cfg_wdata = '0;

    logic              s_valid              = 1'b0;
    logic              s_ready;
    logic              s_need_entry         = 1'b0;
    logic              s_dual_allowed       = 1'b0;
    logic [ADDR_W-1:0] s_first_fetch_pc     = '0;
    logic [ADDR_W-1:0] s_second_fetch_pc    = '0;
    logic [ADDR_W-1:0] s_first_entry_start  = '0;
    logic [ADDR_W-1:0] s_first_branch_pc    = '0;
    logic              s_first_taken        = 1'b0;
    logic [ADDR_W-1:0] s_second_entry_start = '0;
    logic [ADDR_W-1:0] s_second_branch_pc   = '0;
    logic              s_second_taken       = 1'b0;

    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [2:0]       m_verdict;
    logic [LEN_W-1:0] m_first_valid_len;
    logic [LEN_W-1:0] m_second_valid_len;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    dual_verdict_board board = new();

    dual_fetch_bank_conflict_check_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_need_entry         (s_need_entry),
        .s_dual_allowed       (s_dual_allowed),
        .s_first_fetch_pc     (s_first_fetch_pc),
        .s_second_fetch_pc    (s_second_fetch_pc),
        .s_first_entry_start  (s_first_entry_start),
        .s_first_branch_pc    (s_first_branch_pc),
        .s_first_taken        (s_first_taken),
        .s_second_entry_start (s_second_entry_start),
        .s_second_branch_pc   (s_second_branch_pc),
        .s_second_taken       (s_second_taken),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_verdict            (m_verdict),
        .m_first_valid_len    (m_first_valid_len),
        .m_second_valid_len   (m_second_valid_len)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    initial begin
        #2000000;
        $display("timeout: handshakes stopped moving");
        $display("CHECKS FAILED");
        $finish;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watch both channels at the rising edge; note the request before checking
    always @(posedge aclk) begin : watch
        request_t seen;
        if (aresetn && s_valid && s_ready) begin
            seen.need_entry         = s_need_entry;
            seen.dual_allowed       = s_dual_allowed;
            seen.first_fetch_pc     = s_first_fetch_pc;
            seen.second_fetch_pc    = s_second_fetch_pc;
            seen.first_entry_start  = s_first_entry_start;
            seen.first_branch_pc    = s_first_branch_pc;
            seen.first_taken        = s_first_taken;
            seen.second_entry_start = s_second_entry_start;
            seen.second_branch_pc   = s_second_branch_pc;
            seen.second_taken       = s_second_taken;
            board.note_request(seen);
        end
        if (aresetn && m_valid === 1'b1 && m_ready)
            board.check_result(m_verdict, m_first_valid_len, m_second_valid_len);
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input request_t r);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_need_entry         <= r.need_entry;
        s_dual_allowed       <= r.dual_allowed;
        s_first_fetch_pc     <= r.first_fetch_pc;
        s_second_fetch_pc    <= r.second_fetch_pc;
        s_first_entry_start  <= r.first_entry_start;
        s_first_branch_pc    <= r.first_branch_pc;
        s_first_taken        <= r.first_taken;
        s_second_entry_start <= r.second_entry_start;
        s_second_branch_pc   <= r.second_branch_pc;
        s_second_taken       <= r.second_taken;
        s_valid              <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // stop sending and wait for every outstanding verdict
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (board.pending_verdicts.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FBB_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        board.apply_reg(idx, val);
        @(negedge aclk);
    endtask

    // a pair in one page, both taken, ranges in different lines and different banks
    function automatic request_t base_req();
        request_t r;
        r.need_entry         = 1'b1;
        r.dual_allowed       = 1'b1;
        r.first_fetch_pc     = 48'h1000;
        r.second_fetch_pc    = 48'h1040;
        r.first_entry_start  = 48'h1000;
        r.first_branch_pc    = 48'h1004;
        r.first_taken        = 1'b1;
        r.second_entry_start = 48'h1048;
        r.second_branch_pc   = 48'h104C;
        r.second_taken       = 1'b1;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] any_addr();
        logic [63:0] x;
        x = {$urandom, $urandom};
        // now and then crowd the top of the address space
        if ($urandom_range(9) == 0) x[ADDR_W-1:8] = '1;
        return x[ADDR_W-1:0];
    endfunction

    // branch offset from an entry start: mostly short, some long, some backwards
    function automatic logic [ADDR_W-1:0] branch_offset();
        logic [ADDR_W-1:0] d;
        case ($urandom_range(19))
            0: d = ADDR_W'($urandom_range(6000, 4000));
            1: begin
                d = ADDR_W'($urandom_range(64, 1));
                d = -d;
            end
            default: d = ADDR_W'($urandom_range(60));
        endcase
        return d;
    endfunction

    // mostly well-formed pairs with random content, then broken ones and noise
    function automatic request_t make_request(input logic [FBB_W-1:0] fb);
        request_t          r;
        logic [ADDR_W-1:0] page;
        int unsigned       room;
        int unsigned       pick;
        int unsigned       k;
        page = any_addr();
        page[PAGE_BITS-1:0] = '0;
        room = (fb == 0) ? 4095 : 4096 - fb;
        r.need_entry        = 1'b1;
        r.dual_allowed      = 1'b1;
        r.first_taken       = 1'b1;
        r.second_taken      = 1'b1;
        r.first_fetch_pc    = page + ADDR_W'($urandom_range(room));
        r.second_fetch_pc   = page + ADDR_W'($urandom_range(room));
        r.first_entry_start = any_addr();
        r.first_branch_pc   = r.first_entry_start + branch_offset();
        if ($urandom_range(1))
            r.second_entry_start = r.first_entry_start + ADDR_W'($urandom_range(160));
        else
            r.second_entry_start = r.first_entry_start - ADDR_W'($urandom_range(160));
        r.second_branch_pc = r.second_entry_start + branch_offset();
        pick = $urandom_range(99);
        if (pick >= 85) begin
            r.need_entry         = 1'($urandom_range(1));
            r.dual_allowed       = 1'($urandom_range(1));
            r.first_fetch_pc     = any_addr();
            r.second_fetch_pc    = any_addr();
            r.first_entry_start  = any_addr();
            r.first_branch_pc    = any_addr();
            r.first_taken        = 1'($urandom_range(1));
            r.second_entry_start = any_addr();
            r.second_branch_pc   = any_addr();
            r.second_taken       = 1'($urandom_range(1));
        end else if (pick >= 60) begin
            case ($urandom_range(7))
                0: r.need_entry = 1'b0;
                1: r.dual_allowed = 1'b0;
                2: r.first_fetch_pc = '0;
                3: r.second_fetch_pc = '0;
                4: begin
                    k = $urandom_range(ADDR_W - 1, PAGE_BITS);
                    r.second_fetch_pc[k] = ~r.second_fetch_pc[k];
                end
                5: r.first_fetch_pc[PAGE_BITS-1:0] = 12'hFFF - 12'($urandom_range(15));
                6: r.first_taken = 1'b0;
                default: r.second_taken = 1'b0;
            endcase
        end
        return r;
    endfunction

    initial begin
        request_t         r;
        logic             en;
        logic [FBB_W-1:0] fb;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: dual fetch off, so a good pair still falls back
        send_request(base_req());
        r = '1;
        r.need_entry = 1'b0;
        send_request(r);
        wait_drained();
        write_reg(CFG_DUAL_EN, 8'd1);
        write_reg(CFG_FETCH_BUF, 8'd64);

        // permission, zero pcs, page span and fallthrough
        r = base_req(); r.dual_allowed = 1'b0; send_request(r);
        r = base_req(); r.first_fetch_pc = '0; send_request(r);
        r = base_req(); r.second_fetch_pc = '0; send_request(r);
        r = base_req(); r.second_fetch_pc = 48'h2040; send_request(r);
        r = base_req(); r.first_fetch_pc = 48'h1FC0; send_request(r);
        r = base_req(); r.first_fetch_pc = 48'h1FC1; send_request(r);
        r = base_req(); r.second_fetch_pc = 48'h1FC1; send_request(r);
        r = base_req();
        r.first_fetch_pc  = 48'hFFFF_FFFF_FFC0;
        r.second_fetch_pc = 48'hFFFF_FFFF_FFC0;
        send_request(r);
        r.first_fetch_pc  = 48'hFFFF_FFFF_FFC1;
        r.second_fetch_pc = 48'hFFFF_FFFF_F000;
        send_request(r);
        r = base_req(); r.first_taken = 1'b0; send_request(r);
        r = base_req(); r.second_taken = 1'b0; send_request(r);

        // bank check: same bank a line apart, union in one line, saturated lengths
        send_request(base_req());
        r = base_req(); r.second_entry_start = 48'h1040; r.second_branch_pc = 48'h1044;
        send_request(r);
        r = base_req(); r.second_entry_start = 48'h1010; r.second_branch_pc = 48'h1010;
        send_request(r);
        r = base_req(); r.first_branch_pc = 48'hFFC; send_request(r);
        r = base_req(); r.first_branch_pc = 48'h1000 + 48'd4091; send_request(r);
        r = base_req();
        r.first_entry_start  = 48'h2000;
        r.first_branch_pc    = 48'h2038;
        r.second_entry_start = 48'h2038;
        r.second_branch_pc   = 48'h203C;
        send_request(r);
        r.second_entry_start = 48'h203C;
        r.second_branch_pc   = 48'h2040;
        send_request(r);
        r = base_req();
        r.first_entry_start  = 48'hFFFF_FFFF_FFF8;
        r.first_branch_pc    = 48'hFFFF_FFFF_FFFC;
        r.second_entry_start = 48'h40;
        r.second_branch_pc   = 48'h44;
        send_request(r);
        r.first_entry_start  = '1 - 48'd3;
        r.first_branch_pc    = '1 - 48'd3;
        r.second_entry_start = '0;
        r.second_branch_pc   = '0;
        send_request(r);

        // zero buffer size ends the fetch one byte before its start
        wait_drained();
        write_reg(CFG_FETCH_BUF, 8'd0);
        send_request(base_req());
        r = base_req(); r.first_fetch_pc = 48'h1004; send_request(r);
        wait_drained();
        write_reg(CFG_FETCH_BUF, 8'd255);
        r = base_req(); r.first_fetch_pc = 48'h1F01; send_request(r);
        r = base_req(); r.first_fetch_pc = 48'h1F02; send_request(r);

        // random phases: one register setting and one idling pattern each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            en = 1'b1;
            case (ph)
                0: fb = 8'd64;
                1: fb = 8'd4;
                2: fb = 8'd128;
                3: begin en = 1'b0; fb = FBB_W'($urandom_range(128, 4)); end
                4: fb = 8'd0;
                5: fb = 8'd255;
                6: fb = FBB_W'($urandom_range(128, 4));
                default: fb = FBB_W'($urandom_range(255));
            endcase
            write_reg(CFG_DUAL_EN, {7'b0, en});
            write_reg(CFG_FETCH_BUF, fb);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // hold off until the block has emptied out
                if ((ph == 1 || ph == 5) && n == PHASE_WORDS / 2)
                    wait_drained();
                send_request(make_request(fb));
            end
        end

        wait_drained();
        repeat (6) @(posedge aclk);
        if (board.pending_verdicts.size() != 0)
            board.flag_mismatch($sformatf("%0d verdicts never arrived",
                                          board.pending_verdicts.size()));
        $display("covered %0d request words over %0d register/idling phases",
                 board.requests, NUM_PHASES);
        $display("verdicts idle/dual/single/bad pc/page/fallthru/conflict: %0d %0d %0d %0d %0d %0d %0d",
                 board.verdict_count[VERDICT_IDLE], board.verdict_count[VERDICT_DUAL],
                 board.verdict_count[VERDICT_SINGLE], board.verdict_count[VERDICT_BAD_PC],
                 board.verdict_count[VERDICT_PAGE], board.verdict_count[VERDICT_FALLTHRU],
                 board.verdict_count[VERDICT_CONFLICT]);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
